>>> hw/rtl/bcc_pkg.sv
// Shared types and constants for the button click/combo classifier.
// Payload structs, event codes, register indexes and combo pair tables.
// No dependencies.
package bcc_pkg;

  localparam int BTN_MAX  = 4;
  localparam int COMBO_N  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } bcc_event_t;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_HOLD_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_HOLD_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_HOLD_C = 3'd6;

  localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;
  localparam logic [3:0]  ACTIVE_LOW_RST   = 4'hF;
  localparam logic [15:0] COMBO_HOLD_A_RST = 16'd2000;
  localparam logic [15:0] COMBO_HOLD_B_RST = 16'd3000;
  localparam logic [15:0] COMBO_HOLD_C_RST = 16'd100;

  // button pairs: combo 0 = 0+1, combo 1 = 2+3, combo 2 = 1+2
  localparam logic [1:0] COMBO_FIRST  [COMBO_N] = '{2'd0, 2'd2, 2'd1};
  localparam logic [1:0] COMBO_SECOND [COMBO_N] = '{2'd1, 2'd3, 2'd2};

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  raw_levels;
  } bcc_in_t;

  typedef struct packed {
    logic [1:0] event_button0;
    logic [1:0] event_button1;
    logic [1:0] event_button2;
    logic [1:0] event_button3;
    logic [3:0] pressed_mask;
    logic [2:0] combo_fired;
    logic [2:0] combo_holding;
  } bcc_out_t;

  // timing settings shared by all button lanes
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] double_click_ms;
  } bcc_lane_cfg_t;

  typedef struct packed {
    logic [15:0] hold_a_ms;
    logic [15:0] hold_b_ms;
    logic [15:0] hold_c_ms;
  } bcc_combo_cfg_t;

endpackage

>>> hw/rtl/bcc_lane.sv
// One button lane: debounce, press/release edges, short/long/double classification.
// Depends on bcc_pkg.
module bcc_lane import bcc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 lvl,
  input  logic [TIME_BITS-1:0] now,
  input  bcc_lane_cfg_t        cfg,
  output logic [1:0]           ev,
  output logic                 held_nxt_o
);

  localparam int CW = (TIME_BITS > 17) ? TIME_BITS : 17;

  logic                 prev_raw_r, prev_raw_nxt;
  logic                 stable_r, stable_nxt;
  logic                 held_r, held_nxt;
  logic                 long_r, long_nxt;
  logic [TIME_BITS-1:0] press_r, press_nxt;
  logic [TIME_BITS-1:0] rel_r, rel_nxt;
  logic [TIME_BITS-1:0] chg_r, chg_nxt;
  logic [1:0]           tally_r, tally_nxt;

  logic [TIME_BITS-1:0] el_chg, el_rel, el_press, el_rel_nxt;
  logic [1:0]           tally_inc;
  bcc_event_t           ev_c;

  always_comb begin
    prev_raw_nxt = lvl;
    chg_nxt      = (lvl != prev_raw_r) ? now : chg_r;
    el_chg       = now - chg_nxt;
    el_rel       = now - rel_r;
    el_press     = now - press_r;
    tally_inc    = (tally_r < 2'd3) ? tally_r + 2'd1 : tally_r;
    stable_nxt   = stable_r;
    held_nxt     = held_r;
    long_nxt     = long_r;
    press_nxt    = press_r;
    rel_nxt      = rel_r;
    tally_nxt    = tally_r;
    ev_c         = EV_NONE;
    if (CW'(el_chg) > CW'(cfg.debounce_ms)) begin
      if (lvl != stable_r) begin
        stable_nxt = lvl;
        if (lvl) begin
          held_nxt  = 1'b1;
          press_nxt = now;
          long_nxt  = 1'b0;
          if (CW'(el_rel) < CW'(cfg.double_click_ms)) begin
            if (tally_inc >= 2'd2) begin
              ev_c      = EV_DOUBLE;
              tally_nxt = 2'd0;
            end else begin
              tally_nxt = tally_inc;
            end
          end else begin
            tally_nxt = 2'd1;
          end
        end else begin
          held_nxt = 1'b0;
          rel_nxt  = now;
          if (!long_r && CW'(el_press) < CW'(cfg.long_press_ms) && tally_r == 2'd1) begin
            ev_c = EV_SHORT;
          end
        end
      end else if (held_r && !long_r) begin
        if (CW'(el_press) >= CW'(cfg.long_press_ms)) begin
          ev_c      = EV_LONG;
          long_nxt  = 1'b1;
          tally_nxt = 2'd0;
        end
      end
    end
    // click timeout runs on the updated release time
    el_rel_nxt = now - rel_nxt;
    if (!held_nxt && CW'(el_rel_nxt) > CW'({cfg.double_click_ms, 1'b0})) begin
      tally_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= 1'b0;
      stable_r   <= 1'b0;
      held_r     <= 1'b0;
      long_r     <= 1'b0;
      press_r    <= '0;
      rel_r      <= '0;
      chg_r      <= '0;
      tally_r    <= 2'd0;
    end else if (step_en) begin
      prev_raw_r <= prev_raw_nxt;
      stable_r   <= stable_nxt;
      held_r     <= held_nxt;
      long_r     <= long_nxt;
      press_r    <= press_nxt;
      rel_r      <= rel_nxt;
      chg_r      <= chg_nxt;
      tally_r    <= tally_nxt;
    end
  end

  assign ev         = ev_c;
  assign held_nxt_o = held_nxt;

endmodule

>>> hw/rtl/bcc_combo.sv
// Merge stage: evaluates the three two-button combos on the lanes' new held flags.
// Depends on bcc_pkg.
module bcc_combo import bcc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [BTN_MAX-1:0]   held,
  input  logic [TIME_BITS-1:0] now,
  input  bcc_combo_cfg_t       cfg,
  output logic [COMBO_N-1:0]   fired,
  output logic [COMBO_N-1:0]   holding
);

  localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic [COMBO_N-1:0]   act_r, act_nxt;
  logic [COMBO_N-1:0]   done_r, done_nxt;
  logic [COMBO_N-1:0]   both;
  logic [TIME_BITS-1:0] stamp_r   [COMBO_N];
  logic [TIME_BITS-1:0] stamp_nxt [COMBO_N];
  logic [TIME_BITS-1:0] el        [COMBO_N];
  logic [15:0]          hold_ms   [COMBO_N];

  assign hold_ms[0] = cfg.hold_a_ms;
  assign hold_ms[1] = cfg.hold_b_ms;
  assign hold_ms[2] = cfg.hold_c_ms;

  always_comb begin
    for (int k = 0; k < COMBO_N; k++) begin
      both[k]      = held[COMBO_FIRST[k]] && held[COMBO_SECOND[k]];
      el[k]        = now - stamp_r[k];
      act_nxt[k]   = act_r[k];
      done_nxt[k]  = done_r[k];
      stamp_nxt[k] = stamp_r[k];
      fired[k]     = 1'b0;
      if (both[k] && !act_r[k]) begin
        act_nxt[k]   = 1'b1;
        stamp_nxt[k] = now;
        done_nxt[k]  = 1'b0;
      end else if (both[k] && !done_r[k]) begin
        if (CW'(el[k]) >= CW'(hold_ms[k])) begin
          done_nxt[k] = 1'b1;
          fired[k]    = 1'b1;
        end
      end else if (!both[k] && act_r[k]) begin
        act_nxt[k]   = 1'b0;
        stamp_nxt[k] = '0;
        done_nxt[k]  = 1'b0;
      end
      holding[k] = act_nxt[k] && done_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      done_r <= '0;
      for (int k = 0; k < COMBO_N; k++) begin
        stamp_r[k] <= '0;
      end
    end else if (step_en) begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      for (int k = 0; k < COMBO_N; k++) begin
        stamp_r[k] <= stamp_nxt[k];
      end
    end
  end

endmodule

>>> hw/rtl/button_click_combo_classifier_core.sv
// Top level of the button click/combo classifier: config registers, button
// lanes, combo merge stage and output register. Depends on bcc_pkg, bcc_lane, bcc_combo.
//
//   channel | signals                         | direction
//   in      | in_valid, in_ready, in_data     | item in (bcc_in_t)
//   out     | out_valid, out_ready, out_data  | result out (bcc_out_t)
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One item per cycle while in_ready is high: lanes and combo stage update state in the
// accepting cycle, the result appears in the output register in the next cycle.
// in_ready is low only while the output register holds a result not being taken.
// cfg_ready is always high. Synchronous active-low reset of all state but out_data.
module button_click_combo_classifier_core import bcc_pkg::*; #(
  parameter int NUM_BUTTONS = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bcc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bcc_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bcc_lane_cfg_t  lane_cfg_r;
  bcc_combo_cfg_t combo_cfg_r;
  logic [3:0]     active_low_r;

  logic                 step_en;
  logic [TIME_BITS-1:0] now;
  logic [BTN_MAX-1:0]   lvl;
  logic [BTN_MAX-1:0]   held;
  logic [1:0]           ev [BTN_MAX];
  logic [COMBO_N-1:0]   fired, holding;
  logic                 out_valid_r;
  bcc_out_t             out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_cfg_r.debounce_ms     <= DEBOUNCE_RST;
      lane_cfg_r.long_press_ms   <= LONG_PRESS_RST;
      lane_cfg_r.double_click_ms <= DOUBLE_CLICK_RST;
      active_low_r               <= ACTIVE_LOW_RST;
      combo_cfg_r.hold_a_ms      <= COMBO_HOLD_A_RST;
      combo_cfg_r.hold_b_ms      <= COMBO_HOLD_B_RST;
      combo_cfg_r.hold_c_ms      <= COMBO_HOLD_C_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     lane_cfg_r.debounce_ms     <= cfg_data;
        REG_LONG_PRESS:   lane_cfg_r.long_press_ms   <= cfg_data;
        REG_DOUBLE_CLICK: lane_cfg_r.double_click_ms <= cfg_data;
        REG_ACTIVE_LOW:   active_low_r               <= cfg_data[3:0];
        REG_COMBO_HOLD_A: combo_cfg_r.hold_a_ms      <= cfg_data;
        REG_COMBO_HOLD_B: combo_cfg_r.hold_b_ms      <= cfg_data;
        REG_COMBO_HOLD_C: combo_cfg_r.hold_c_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign step_en  = in_valid && in_ready;
  assign now      = in_data.now_ms[TIME_BITS-1:0];
  assign lvl      = in_data.raw_levels ^ active_low_r;

  for (genvar i = 0; i < BTN_MAX; i++) begin : g_btn
    if (i < NUM_BUTTONS) begin : g_lane
      bcc_lane #(.TIME_BITS(TIME_BITS)) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .lvl        (lvl[i]),
        .now        (now),
        .cfg        (lane_cfg_r),
        .ev         (ev[i]),
        .held_nxt_o (held[i])
      );
    end else begin : g_unused
      assign ev[i]   = EV_NONE;
      assign held[i] = 1'b0;
    end
  end

  bcc_combo #(.TIME_BITS(TIME_BITS)) u_combo (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .held    (held),
    .now     (now),
    .cfg     (combo_cfg_r),
    .fired   (fired),
    .holding (holding)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r.event_button0 <= ev[0];
      out_data_r.event_button1 <= ev[1];
      out_data_r.event_button2 <= ev[2];
      out_data_r.event_button3 <= ev[3];
      out_data_r.pressed_mask  <= held;
      out_data_r.combo_fired   <= fired;
      out_data_r.combo_holding <= holding;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for button_click_combo_classifier_core: a queue-fed driver,
// a stalling monitor and a cycle-level predictor of the debounce, click and combo logic.
// Depends on bcc_pkg and the core RTL only.
module tb_top;
  import bcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {SPAN_GLITCH, SPAN_SHORT, SPAN_LONG, SPAN_GAP, SPAN_IDLE} span_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  bcc_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bcc_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  button_click_combo_classifier_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  bit [15:0] debounce_ms_r = DEBOUNCE_RST;
  bit [15:0] long_ms_r     = LONG_PRESS_RST;
  bit [15:0] dbl_ms_r      = DOUBLE_CLICK_RST;
  bit [3:0]  act_low_r     = ACTIVE_LOW_RST;
  bit [15:0] hold_ms_r [COMBO_N] = '{COMBO_HOLD_A_RST, COMBO_HOLD_B_RST, COMBO_HOLD_C_RST};

  // classifier state, everything released after reset
  bit        raw_prev [BTN_MAX];
  bit        level_stable [BTN_MAX];
  bit        held [BTN_MAX];
  bit        long_done [BTN_MAX];
  bit [31:0] t_press [BTN_MAX];
  bit [31:0] t_release [BTN_MAX];
  bit [31:0] t_change [BTN_MAX];
  bit [1:0]  tally [BTN_MAX];
  bit        combo_on [COMBO_N];
  bit        combo_hit [COMBO_N];
  bit [31:0] t_combo [COMBO_N];

  bcc_in_t  item_q [$];
  bcc_out_t expected_q [$];
  int       n_queued, n_checked, n_errors, n_settings;
  int       n_short, n_long, n_double, n_combo;
  int       burst_left, gap_left;
  int       cycle_count;
  bit [31:0] t_cursor;

  function automatic bcc_out_t classify_step(bcc_in_t item);
    bcc_out_t   res;
    bcc_event_t ev [BTN_MAX];
    bit [31:0]  now;
    bit [3:0]   lvl;
    bit         both;
    res = '0;
    now = item.now_ms;
    lvl = item.raw_levels ^ act_low_r;
    for (int i = 0; i < BTN_MAX; i++) begin
      ev[i] = EV_NONE;
      if (lvl[i] != raw_prev[i]) t_change[i] = now;
      if (now - t_change[i] > 32'(debounce_ms_r)) begin
        if (lvl[i] != level_stable[i]) begin
          level_stable[i] = lvl[i];
          if (lvl[i]) begin
            held[i] = 1'b1;
            t_press[i] = now;
            long_done[i] = 1'b0;
            if (now - t_release[i] < 32'(dbl_ms_r)) begin
              if (tally[i] < 2'd3) tally[i]++;
              if (tally[i] >= 2'd2) begin
                ev[i] = EV_DOUBLE;
                tally[i] = 2'd0;
              end
            end else begin
              tally[i] = 2'd1;
            end
          end else begin
            held[i] = 1'b0;
            t_release[i] = now;
            if (!long_done[i] && (now - t_press[i] < 32'(long_ms_r)) && tally[i] == 2'd1)
              ev[i] = EV_SHORT;
          end
        end else if (held[i] && !long_done[i]) begin
          if (now - t_press[i] >= 32'(long_ms_r)) begin
            ev[i] = EV_LONG;
            long_done[i] = 1'b1;
            tally[i] = 2'd0;
          end
        end
      end
      // click count expires after twice the double-click window
      if (!held[i] && (now - t_release[i] > 32'(dbl_ms_r) * 2)) tally[i] = 2'd0;
      raw_prev[i] = lvl[i];
      res.pressed_mask[i] = held[i];
      if (ev[i] == EV_SHORT) n_short++;
      if (ev[i] == EV_LONG) n_long++;
      if (ev[i] == EV_DOUBLE) n_double++;
    end
    res.event_button0 = ev[0];
    res.event_button1 = ev[1];
    res.event_button2 = ev[2];
    res.event_button3 = ev[3];
    for (int k = 0; k < COMBO_N; k++) begin
      both = held[COMBO_FIRST[k]] && held[COMBO_SECOND[k]];
      if (both && !combo_on[k]) begin
        combo_on[k] = 1'b1;
        t_combo[k] = now;
        combo_hit[k] = 1'b0;
      end else if (both && !combo_hit[k]) begin
        if (now - t_combo[k] >= 32'(hold_ms_r[k])) begin
          combo_hit[k] = 1'b1;
          res.combo_fired[k] = 1'b1;
          n_combo++;
        end
      end else if (!both && combo_on[k]) begin
        combo_on[k] = 1'b0;
        t_combo[k] = '0;
        combo_hit[k] = 1'b0;
      end
      res.combo_holding[k] = combo_on[k] && combo_hit[k];
    end
    return res;
  endfunction

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(classify_step(in_data));
      if (in_valid && !in_ready) begin
        // payload held until taken
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (item_q.size() != 0) begin
        in_data <= item_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // monitor: compares results in order, backpressure follows its own mode pattern
  int ready_mode, mode_left;
  always @(posedge clk) begin : monitor
    bcc_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_mode <= 0;
      mode_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          want = expected_q.pop_front();
          check_field("event_button0", want.event_button0, out_data.event_button0);
          check_field("event_button1", want.event_button1, out_data.event_button1);
          check_field("event_button2", want.event_button2, out_data.event_button2);
          check_field("event_button3", want.event_button3, out_data.event_button3);
          check_field("pressed_mask", want.pressed_mask, out_data.pressed_mask);
          check_field("combo_fired", want.combo_fired, out_data.combo_fired);
          check_field("combo_holding", want.combo_holding, out_data.combo_holding);
          n_checked++;
        end
      end
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cycle_count % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d of %0d transactions checked", $time, n_checked, n_queued);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE:     debounce_ms_r = val;
      REG_LONG_PRESS:   long_ms_r = val;
      REG_DOUBLE_CLICK: dbl_ms_r = val;
      REG_ACTIVE_LOW:   act_low_r = val[3:0];
      REG_COMBO_HOLD_A: hold_ms_r[0] = val;
      REG_COMBO_HOLD_B: hold_ms_r[1] = val;
      REG_COMBO_HOLD_C: hold_ms_r[2] = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] deb, logic [15:0] lng, logic [15:0] dbl,
                                logic [15:0] msk, logic [15:0] ha, logic [15:0] hb,
                                logic [15:0] hc);
    write_reg(REG_UNUSED, 16'($urandom));  // out-of-range index must be ignored
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_DOUBLE_CLICK, dbl);
    write_reg(REG_ACTIVE_LOW, msk);
    write_reg(REG_COMBO_HOLD_A, ha);
    write_reg(REG_COMBO_HOLD_B, hb);
    write_reg(REG_COMBO_HOLD_C, hc);
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (n_checked != n_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic emit(bit [3:0] raw);
    bcc_in_t it;
    it.now_ms = t_cursor;
    it.raw_levels = raw;
    item_q.push_back(it);
    n_queued++;
  endtask

  function automatic int unsigned span_ms(span_kind_t kind);
    int unsigned d, l, w;
    d = debounce_ms_r;
    l = long_ms_r;
    w = dbl_ms_r;
    case (kind)
      SPAN_GLITCH: return $urandom_range(0, d);
      SPAN_SHORT:  return d + $urandom_range(1, l + 1);
      SPAN_LONG:   return d + l + $urandom_range(1, l / 2 + 50);
      SPAN_GAP:    return (w > d + 1) ? $urandom_range(d + 1, w - 1) : d + 1;
      default:     return d + 2 * w + $urandom_range(1, 500);
    endcase
  endfunction

  // holds a logical pressed pattern for dur ms, optionally with contact bounce first
  task automatic hold_buttons(bit [3:0] pressed, int unsigned dur);
    int unsigned spent, stride, max_step;
    max_step = dur / 4 + 1;
    spent = 0;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        t_cursor += $urandom_range(0, 2);
        emit(4'($urandom));
      end
    end
    emit(pressed ^ act_low_r);
    while (spent <= dur) begin
      stride = $urandom_range(1, max_step);
      t_cursor += stride;
      spent += stride;
      emit(pressed ^ act_low_r);
    end
  endtask

  task automatic gen_press_scripts(int count);
    int        start, k;
    bit [3:0]  pat;
    start = n_queued;
    while (n_queued - start < count) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 5)) begin
            t_cursor += ($urandom_range(0, 4) == 0) ? $urandom
                                                    : $urandom_range(0, 3 * debounce_ms_r + 10);
            emit(4'($urandom));
          end
        end
        1, 2: begin
          pat = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'(1 << $urandom_range(0, 3));
          hold_buttons(pat, debounce_ms_r + $urandom_range(1, dbl_ms_r + 1));
          hold_buttons(4'b0, span_ms(SPAN_GAP));
          hold_buttons(pat, span_ms($urandom_range(0, 3) == 0 ? SPAN_LONG : SPAN_SHORT));
          hold_buttons(4'b0, span_ms($urandom_range(0, 1) ? SPAN_IDLE : SPAN_GAP));
        end
        3, 4: begin
          k = $urandom_range(0, COMBO_N - 1);
          pat = '0;
          pat[COMBO_FIRST[k]] = 1'b1;
          pat[COMBO_SECOND[k]] = 1'b1;
          if ($urandom_range(0, 3) == 0) pat |= 4'($urandom);
          hold_buttons(pat, ($urandom_range(0, 3) == 0) ? $urandom_range(0, hold_ms_r[k])
                            : debounce_ms_r + hold_ms_r[k] + $urandom_range(0, 100));
          hold_buttons(4'b0, span_ms(span_kind_t'($urandom_range(0, 4))));
        end
        default: begin
          hold_buttons(4'($urandom), span_ms(span_kind_t'($urandom_range(0, 4))));
        end
      endcase
    end
  endtask

  // single and double click, long press, pair 1+2 combo, then all buttons
  // across the time wrap and with time running backwards
  task automatic gen_directed();
    bit [31:0] stamps [22] = '{
      32'd0, 32'd10, 32'd61, 32'd100, 32'd151, 32'd200, 32'd251, 32'd1300,
      32'd1400, 32'd1451, 32'd2000, 32'd2051, 32'd2151, 32'd2200, 32'd2300, 32'd2351,
      32'hFFFF_FFC0, 32'h0000_0010, 32'h0000_0BC0, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hFFFF_FFFF};
    bit [3:0] pressed [22] = '{
      4'b0000, 4'b0001, 4'b0001, 4'b0000, 4'b0000, 4'b0001, 4'b0001, 4'b0001,
      4'b0000, 4'b0000, 4'b0110, 4'b0110, 4'b0110, 4'b0110, 4'b0000, 4'b0000,
      4'b1111, 4'b1111, 4'b1111, 4'b1010, 4'b0101, 4'b0000};
    for (int i = 0; i < 22; i++) begin
      t_cursor = stamps[i];
      emit(pressed[i] ^ act_low_r);
    end
  endtask

  // half the items, a full drain with the sender idle, then the rest
  task automatic run_phase(int count);
    gen_press_scripts(count / 2);
    wait_drained();
    gen_press_scripts(count - count / 2);
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n_settings = 1;
    gen_directed();
    wait_drained();
    t_cursor = 32'd5000;
    run_phase(240);

    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(240);

    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(240);

    apply_settings(16'd5, 16'd40, 16'd60, 16'h5, 16'd30, 16'd200, 16'd0);
    run_phase(240);

    repeat (2) begin
      apply_settings(16'($urandom_range(0, 100)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 800)), 16'($urandom),
                     16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                     16'($urandom_range(0, 3000)));
      t_cursor = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      run_phase(240);
    end

    apply_settings(DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST, 16'(ACTIVE_LOW_RST),
                   COMBO_HOLD_A_RST, COMBO_HOLD_B_RST, COMBO_HOLD_C_RST);
    run_phase(240);

    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_q.size());
    end
    $display("Checked %0d transactions under %0d register settings, with wrapping timestamps.",
             n_checked, n_settings);
    $display("Predicted %0d short, %0d long, %0d double clicks and %0d combo fires; %0d errors.",
             n_short, n_long, n_double, n_combo, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_lane.sv
hw/rtl/bcc_combo.sv
hw/rtl/button_click_combo_classifier_core.sv
bench/tb_top.sv
